### hw/rtl/tpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpw_pkg;

	// default raw sample width
	localparam int SAMPLE_BITS_DEF = 10;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 3;
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BASELINE_A  = 3'd0,
		REG_BASELINE_B  = 3'd1,
		REG_BASELINE_C  = 3'd2,
		REG_TOUCH_LEVEL = 3'd3,
		REG_MOVE_LEVEL  = 3'd4
	} reg_index_t;

	// threshold reset values
	localparam int TOUCH_LEVEL_RST = 40;
	localparam int MOVE_LEVEL_RST  = 20;

	// touched pad codes
	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_A    = 2'd1,
		PAD_B    = 2'd2,
		PAD_C    = 2'd3
	} pad_t;

	// step codes, two bit signed
	typedef logic signed [1:0] step_t;
	localparam step_t STEP_NONE = 2'sb00;
	localparam step_t STEP_FWD  = 2'sb01;
	localparam step_t STEP_BWD  = 2'sb11;

	// result fields in the output data word
	localparam int OUT_FIELD_BITS = 4;
	localparam int OUT_DATA_BITS  = 8;

endpackage

`default_nettype wire

### hw/rtl/tpw_step_logic.sv
`timescale 1ns / 1ps
`default_nettype none

module tpw_step_logic #(
	parameter int SAMPLE_BITS = tpw_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic [SAMPLE_BITS-1:0] sample_a,
	input  wire logic [SAMPLE_BITS-1:0] sample_b,
	input  wire logic [SAMPLE_BITS-1:0] sample_c,
	input  wire logic [SAMPLE_BITS-1:0] baseline_a,
	input  wire logic [SAMPLE_BITS-1:0] baseline_b,
	input  wire logic [SAMPLE_BITS-1:0] baseline_c,
	input  wire logic [SAMPLE_BITS-1:0] touch_level,
	input  wire logic [SAMPLE_BITS-1:0] move_level,
	input  wire tpw_pkg::pad_t          pad_cur,
	output tpw_pkg::pad_t               pad_next,
	output tpw_pkg::step_t              step
);

	localparam int LV_BITS = SAMPLE_BITS + 1;
	localparam int DF_BITS = SAMPLE_BITS + 2;

	logic signed [LV_BITS-1:0] lv_a, lv_b, lv_c;
	logic signed [LV_BITS-1:0] lv_cur, lv_fwd, lv_bwd;
	logic signed [LV_BITS-1:0] hi;
	logic signed [DF_BITS-1:0] lo;
	logic signed [DF_BITS-1:0] lead_fwd, lead_bwd;
	tpw_pkg::pad_t             pad_fwd, pad_bwd;

	// signed pad levels after baseline removal
	assign lv_a = $signed({1'b0, sample_a}) - $signed({1'b0, baseline_a});
	assign lv_b = $signed({1'b0, sample_b}) - $signed({1'b0, baseline_b});
	assign lv_c = $signed({1'b0, sample_c}) - $signed({1'b0, baseline_c});
	assign hi   = $signed({1'b0, touch_level});
	assign lo   = $signed({2'b00, move_level});

	// neighbors of the touched pad around the wheel
	always_comb begin
		case (pad_cur)
			tpw_pkg::PAD_A: begin
				lv_cur = lv_a; lv_fwd = lv_b; lv_bwd = lv_c;
				pad_fwd = tpw_pkg::PAD_B; pad_bwd = tpw_pkg::PAD_C;
			end
			tpw_pkg::PAD_B: begin
				lv_cur = lv_b; lv_fwd = lv_c; lv_bwd = lv_a;
				pad_fwd = tpw_pkg::PAD_C; pad_bwd = tpw_pkg::PAD_A;
			end
			tpw_pkg::PAD_C: begin
				lv_cur = lv_c; lv_fwd = lv_a; lv_bwd = lv_b;
				pad_fwd = tpw_pkg::PAD_A; pad_bwd = tpw_pkg::PAD_B;
			end
			default: begin
				lv_cur = lv_a; lv_fwd = lv_b; lv_bwd = lv_c;
				pad_fwd = tpw_pkg::PAD_B; pad_bwd = tpw_pkg::PAD_C;
			end
		endcase
	end

	// leads of each neighbor over the touched pad
	assign lead_fwd = DF_BITS'(lv_fwd) - DF_BITS'(lv_cur);
	assign lead_bwd = DF_BITS'(lv_bwd) - DF_BITS'(lv_cur);

	// touch tracking decision
	always_comb begin
		pad_next = pad_cur;
		step     = tpw_pkg::STEP_NONE;
		if (pad_cur == tpw_pkg::PAD_NONE) begin
			if (lv_a > hi) begin
				pad_next = tpw_pkg::PAD_A;
			end else if (lv_b > hi) begin
				pad_next = tpw_pkg::PAD_B;
			end else if (lv_c > hi) begin
				pad_next = tpw_pkg::PAD_C;
			end
		end else begin
			if (lead_fwd > lo) begin
				pad_next = pad_fwd;
				step     = tpw_pkg::STEP_FWD;
			end else if (lead_bwd > lo) begin
				pad_next = pad_bwd;
				step     = tpw_pkg::STEP_BWD;
			end else if (DF_BITS'(lv_cur) < lo) begin
				pad_next = tpw_pkg::PAD_NONE;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/three_pad_touch_wheel_step_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-pad touch wheel step detector. Each transaction on the slave side
// carries one raw sample per pad; the block removes the per-pad baselines,
// tracks the touched pad and returns one result per sample set with the
// step (+1, -1 or 0) and the touched pad (0 = none). One sample set is taken
// every clock cycle while the result side does not stall; a sample set passes
// through the input register and then the result register, with the
// combinational touch decision between them. The user must write baselines and
// thresholds through the cfg port only while no sample set is in flight; the
// block itself does not enforce this.
module three_pad_touch_wheel_step_top #(
	parameter int SAMPLE_BITS = tpw_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// sample_a, sample_b, sample_c from the lowest bit, zero padded
	input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// step, pad_now from the lowest bit, zero padded
	output logic [tpw_pkg::OUT_DATA_BITS-1:0]       m_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic [tpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [SAMPLE_BITS-1:0]             cfg_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready
);

	logic [SAMPLE_BITS-1:0] baseline_a_q, baseline_b_q, baseline_c_q;
	logic [SAMPLE_BITS-1:0] touch_level_q, move_level_q;
	logic [SAMPLE_BITS-1:0] sample_a_s1, sample_b_s1, sample_c_s1;
	logic                   valid_s1;
	logic                   adv_s1;
	logic                   out_free;
	tpw_pkg::pad_t          pad_q;
	tpw_pkg::pad_t          pad_next;
	tpw_pkg::step_t         step_next;
	tpw_pkg::step_t         step_q;
	logic                   out_valid_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_a_q  <= '0;
			baseline_b_q  <= '0;
			baseline_c_q  <= '0;
			touch_level_q <= SAMPLE_BITS'(tpw_pkg::TOUCH_LEVEL_RST);
			move_level_q  <= SAMPLE_BITS'(tpw_pkg::MOVE_LEVEL_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpw_pkg::REG_BASELINE_A:  baseline_a_q  <= cfg_data;
				tpw_pkg::REG_BASELINE_B:  baseline_b_q  <= cfg_data;
				tpw_pkg::REG_BASELINE_C:  baseline_c_q  <= cfg_data;
				tpw_pkg::REG_TOUCH_LEVEL: touch_level_q <= cfg_data;
				tpw_pkg::REG_MOVE_LEVEL:  move_level_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_a_s1 <= s_tdata[SAMPLE_BITS-1:0];
			sample_b_s1 <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			sample_c_s1 <= s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
		end
	end

	// touch decision
	tpw_step_logic #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_step (
		.sample_a    (sample_a_s1),
		.sample_b    (sample_b_s1),
		.sample_c    (sample_c_s1),
		.baseline_a  (baseline_a_q),
		.baseline_b  (baseline_b_q),
		.baseline_c  (baseline_c_q),
		.touch_level (touch_level_q),
		.move_level  (move_level_q),
		.pad_cur     (pad_q),
		.pad_next    (pad_next),
		.step        (step_next)
	);

	// touched pad state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q       <= tpw_pkg::PAD_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				pad_q <= pad_next;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			step_q <= step_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(tpw_pkg::OUT_DATA_BITS - tpw_pkg::OUT_FIELD_BITS){1'b0}},
		pad_q, step_q};

`ifndef ASSERT_OFF
	// touched pad only moves when a sample set enters the result register
	a_pad_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(pad_q))
		else $error("touched pad changed without a transaction");

	// a step always lands on a touched pad
	a_step_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && step_q != tpw_pkg::STEP_NONE) |-> (pad_q != tpw_pkg::PAD_NONE))
		else $error("step reported with no touched pad");

	// a step moves to a different pad
	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && step_next != tpw_pkg::STEP_NONE) |=> (pad_q != $past(pad_q)))
		else $error("step reported without a pad change");

	// a stalled result blocks the input once the stage is full
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while pipeline full");
`endif

endmodule

`default_nettype wire

### verif/three_pad_touch_wheel_step_top_test.sv
`timescale 1ns / 1ps

module three_pad_touch_wheel_step_top_test;
	import tpw_pkg::*;

	localparam int SW             = SAMPLE_BITS_DEF;
	localparam int SAMPLE_MAX     = (1 << SW) - 1;
	localparam int IN_BITS        = ((3 * SW + 7) / 8) * 8;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int SHIFTED_ROW_FIRST = 17;
	localparam int TOUR_ROWS      = 24;
	// first index past the register file, writes there must be dropped
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd5;

	typedef struct packed {
		step_t st;
		pad_t  pad;
	} wheel_result_t;

	typedef struct packed {
		logic [SW-1:0] a;
		logic [SW-1:0] b;
		logic [SW-1:0] c;
		logic          typed;
		step_t         st;
		pad_t          pad;
	} wheel_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	// sample_a, sample_b, sample_c from the lowest bit, zero padded
	logic [IN_BITS-1:0]         s_tdata = '0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	// step, pad_now from the lowest bit, zero padded
	logic [OUT_DATA_BITS-1:0]   m_tdata;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
	logic [SW-1:0]              cfg_data = '0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;

	// predictor copy of the wheel state and registers
	pad_t          wheel_pad = PAD_NONE;
	logic [SW-1:0] base_cfg [3] = '{default: '0};
	logic [SW-1:0] touch_cfg = SW'(TOUCH_LEVEL_RST);
	logic [SW-1:0] move_cfg  = SW'(MOVE_LEVEL_RST);

	wheel_result_t pending_results [$];
	int            fail_count = 0;
	int            quiet_cycles = 0;
	bit            tx_steady = 1'b0;
	bit            rx_steady = 1'b0;

	// synthetic finger for the random part
	int            finger_at = 0;
	bit            finger_down = 1'b0;

	// directed tour, reset thresholds first, then shifted baselines
	wheel_row_t tour [TOUR_ROWS] = '{
		'{10'd0,    10'd0,    10'd0,    1'b1, STEP_NONE, PAD_NONE},
		'{10'd1023, 10'd1023, 10'd1023, 1'b1, STEP_NONE, PAD_A},
		'{10'd0,    10'd0,    10'd0,    1'b1, STEP_NONE, PAD_NONE},
		'{10'd40,   10'd40,   10'd41,   1'b1, STEP_NONE, PAD_C},
		'{10'd61,   10'd0,    10'd41,   1'b1, STEP_NONE, PAD_C},
		'{10'd62,   10'd0,    10'd41,   1'b1, STEP_FWD,  PAD_A},
		'{10'd62,   10'd83,   10'd0,    1'b1, STEP_FWD,  PAD_B},
		'{10'd0,    10'd83,   10'd104,  1'b1, STEP_FWD,  PAD_C},
		'{10'd0,    10'd125,  10'd104,  1'b1, STEP_BWD,  PAD_B},
		'{10'd146,  10'd125,  10'd0,    1'b1, STEP_BWD,  PAD_A},
		'{10'd146,  10'd0,    10'd167,  1'b1, STEP_BWD,  PAD_C},
		'{10'd1023, 10'd1023, 10'd0,    1'b1, STEP_FWD,  PAD_A},
		'{10'd20,   10'd0,    10'd0,    1'b1, STEP_NONE, PAD_A},
		'{10'd19,   10'd0,    10'd0,    1'b1, STEP_NONE, PAD_NONE},
		'{10'd0,    10'd1023, 10'd0,    1'b1, STEP_NONE, PAD_B},
		'{10'd1023, 10'd1023, 10'd1023, 1'b1, STEP_NONE, PAD_B},
		'{10'd0,    10'd0,    10'd0,    1'b1, STEP_NONE, PAD_NONE},
		'{10'd600,  10'd1023, 10'd300,  1'b0, STEP_NONE, PAD_NONE},
		'{10'd601,  10'd0,    10'd300,  1'b0, STEP_NONE, PAD_NONE},
		'{10'd0,    10'd0,    10'd0,    1'b0, STEP_NONE, PAD_NONE},
		'{10'd599,  10'd1023, 10'd299,  1'b0, STEP_NONE, PAD_NONE},
		'{10'd1023, 10'd1023, 10'd1023, 1'b0, STEP_NONE, PAD_NONE},
		'{10'd0,    10'd1023, 10'd0,    1'b0, STEP_NONE, PAD_NONE},
		'{10'd1023, 10'd0,    10'd1023, 1'b0, STEP_NONE, PAD_NONE}
	};

	three_pad_touch_wheel_step_top #(
		.SAMPLE_BITS(SW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic pad_t pad_at(input int idx);
		case (idx)
			0: return PAD_A;
			1: return PAD_B;
			default: return PAD_C;
		endcase
	endfunction

	// wheel tracker: baseline removal, touch, step and release decisions
	function automatic void wheel_predict(input logic [SW-1:0] a, b, c,
			output wheel_result_t res);
		int lv [3];
		int hi, lo, cur, fwd, bwd;
		lv[0] = int'(a) - int'(base_cfg[0]);
		lv[1] = int'(b) - int'(base_cfg[1]);
		lv[2] = int'(c) - int'(base_cfg[2]);
		hi = int'(touch_cfg);
		lo = int'(move_cfg);
		res.st = STEP_NONE;
		if (wheel_pad == PAD_NONE) begin
			if (lv[0] > hi)
				wheel_pad = PAD_A;
			else if (lv[1] > hi)
				wheel_pad = PAD_B;
			else if (lv[2] > hi)
				wheel_pad = PAD_C;
		end else begin
			cur = int'(wheel_pad) - 1;
			fwd = (cur + 1) % 3;
			bwd = (cur + 2) % 3;
			// forward lead wins over backward lead, release comes last
			if (lv[fwd] - lv[cur] > lo) begin
				res.st = STEP_FWD;
				wheel_pad = pad_at(fwd);
			end else if (lv[bwd] - lv[cur] > lo) begin
				res.st = STEP_BWD;
				wheel_pad = pad_at(bwd);
			end else if (lv[cur] < lo) begin
				wheel_pad = PAD_NONE;
			end
		end
		res.pad = wheel_pad;
	endfunction

	function automatic logic [SW-1:0] to_sample(input int lvl, input logic [SW-1:0] base);
		int raw;
		raw = int'(base) + lvl;
		if (raw < 0)
			raw = 0;
		if (raw > SAMPLE_MAX)
			raw = SAMPLE_MAX;
		return SW'(raw);
	endfunction

	// mostly a finger that lands, slides to a neighbor and lifts, some raw noise
	task automatic make_samples(output logic [SW-1:0] a, b, c);
		int lv [3];
		int k;
		if ($urandom_range(0, 9) < 3) begin
			a = SW'($urandom_range(0, SAMPLE_MAX));
			b = SW'($urandom_range(0, SAMPLE_MAX));
			c = SW'($urandom_range(0, SAMPLE_MAX));
		end else begin
			case ($urandom_range(0, 11))
				0: finger_down = !finger_down;
				1: finger_at = (finger_at + 1) % 3;
				2: finger_at = (finger_at + 2) % 3;
				default: ;
			endcase
			if (finger_down) begin
				lv[finger_at] = int'(touch_cfg) + int'($urandom_range(0, 40)) - 20;
				for (k = 1; k < 3; k++) begin
					if ($urandom_range(0, 1) == 1)
						lv[(finger_at + k) % 3] = lv[finger_at] - int'(move_cfg)
							+ int'($urandom_range(0, 30)) - 15;
					else
						lv[(finger_at + k) % 3] = int'($urandom_range(0, 60)) - 30;
				end
			end else begin
				// hover around the release level
				for (k = 0; k < 3; k++)
					lv[k] = int'($urandom_range(0, 40)) - 20
						+ (($urandom_range(0, 1) == 1) ? int'(move_cfg) : 0);
			end
			a = to_sample(lv[0], base_cfg[0]);
			b = to_sample(lv[1], base_cfg[1]);
			c = to_sample(lv[2], base_cfg[2]);
		end
	endtask

	// one sample set transaction, expectation queued at acceptance
	task automatic send_samples(input logic [SW-1:0] a, b, c, input bit typed,
			input wheel_result_t typed_res);
		int gap;
		wheel_result_t want;
		gap = tx_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= IN_BITS'({c, b, a});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		wheel_predict(a, b, c, want);
		if (typed)
			want = typed_res;
		pending_results.push_back(want);
	endtask

	task automatic hold_for_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic drain_wheel();
		hold_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [SW-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BASELINE_A:  base_cfg[0] = data;
			REG_BASELINE_B:  base_cfg[1] = data;
			REG_BASELINE_C:  base_cfg[2] = data;
			REG_TOUCH_LEVEL: touch_cfg = data;
			REG_MOVE_LEVEL:  move_cfg = data;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [SW-1:0] ba, bb, bc, tl, ml);
		write_reg(REG_BASELINE_A, ba);
		write_reg(REG_BASELINE_B, bb);
		write_reg(REG_BASELINE_C, bc);
		write_reg(REG_TOUCH_LEVEL, tl);
		write_reg(REG_MOVE_LEVEL, ml);
		write_reg(CFG_INDEX_BITS'(REG_SPARE + $urandom_range(0, 2)),
			SW'($urandom_range(0, SAMPLE_MAX)));
		cfg_valid <= 1'b0;
	endtask

	// result sink with random stalls
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// result checker
	always @(posedge clk) begin
		wheel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction, m_tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[1:0] !== want.st) begin
					$error("step: expected %0d, actual %0d", want.st, $signed(m_tdata[1:0]));
					fail_count++;
				end
				if (m_tdata[3:2] !== want.pad) begin
					$error("pad_now: expected %0d, actual %0d", want.pad, m_tdata[3:2]);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("three_pad_touch_wheel_step_top_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int i, ph, n;
		logic [SW-1:0] a, b, c;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed tour, shifted baselines give negative levels in the tail
		for (i = 0; i < TOUR_ROWS; i++) begin
			if (i == SHIFTED_ROW_FIRST) begin
				drain_wheel();
				load_settings(SW'(600), SW'(1023), SW'(300), '0, '0);
			end
			send_samples(tour[i].a, tour[i].b, tour[i].c, tour[i].typed,
				'{tour[i].st, tour[i].pad});
		end
		drain_wheel();

		// random phases, each under its own settings
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_settings('0, '0, '0, SW'(TOUCH_LEVEL_RST), SW'(MOVE_LEVEL_RST));
				1: load_settings('0, '0, '0, '0, '0);
				2: load_settings(SW'(SAMPLE_MAX), SW'(SAMPLE_MAX), SW'(SAMPLE_MAX),
					SW'(SAMPLE_MAX), SW'(SAMPLE_MAX));
				3: load_settings('0, '0, '0, '0, SW'(SAMPLE_MAX));
				default: load_settings(SW'($urandom_range(0, 700)), SW'($urandom_range(0, 700)),
					SW'($urandom_range(0, 700)), SW'($urandom_range(0, 200)),
					SW'($urandom_range(0, 100)));
			endcase
			tx_steady = (ph == 2) || (ph == 5);
			rx_steady = (ph == 3) || (ph == 5);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				make_samples(a, b, c);
				send_samples(a, b, c, 1'b0, '{STEP_NONE, PAD_NONE});
				if ($urandom_range(0, 199) == 0)
					hold_for_results();
			end
			drain_wheel();
		end

		if (fail_count == 0)
			$display("three_pad_touch_wheel_step_top_test: PASS");
		else
			$display("three_pad_touch_wheel_step_top_test: FAIL");
		$finish;
	end

endmodule
